/* hdl/hfcc_pkg.sv */
`timescale 1ns / 1ps
// Package for the histogram frame CRC checker.
// Holds the request and result types, CRC constants and the byte-wise CRC function.
package hfcc_pkg;

  localparam int unsigned PosW  = 7;
  localparam int unsigned IdxW  = 6;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic [IdxW-1:0] word_index;
    logic [15:0]     word_value;
    logic            frame_last;
    logic            crc_ok;
  } out_req_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

/* hdl/hfcc_in_if.sv */
`timescale 1ns / 1ps
// Input byte channel of the histogram frame CRC checker.
// Carries valid, ready and one frame byte with its start flag.
interface hfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

/* hdl/hfcc_out_if.sv */
`timescale 1ns / 1ps
// Output word channel of the histogram frame CRC checker.
// Carries valid, ready and one word with its index and checksum flags.
interface hfcc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  word_index;
  logic [15:0] word_value;
  logic        frame_last;
  logic        crc_ok;

  modport source (output valid, output word_index, output word_value,
                  output frame_last, output crc_ok, input ready);
  modport sink   (input valid, input word_index, input word_value,
                  input frame_last, input crc_ok, output ready);
endinterface

/* hdl/histogram_frame_crc_checker.sv */
`timescale 1ns / 1ps
// Histogram frame CRC checker top level: input register, frame core, result register.
// Depends on hfcc_pkg, hfcc_in_if, hfcc_out_if and hfcc_frame_core.

// The block takes one byte per clock cycle while the output is not stalled, with no
// gaps between frames. A byte sits in the input register, where the frame core updates
// the position and the CRC with one byte of unrolled XOR logic, and its word lands in
// the result register: a word is valid on the output once its odd byte has passed both
// registers. Bytes pair little-endian into words; every word of the frame is delivered
// with its index, and the trailing word carries frame_last and crc_ok (received checksum
// equals the CRC-16/MODBUS over all but the last two bytes). A start flag or the end of
// a frame of FRAME_BYTES bytes restarts the position and the CRC. The input keeps
// flowing while a finished word waits, until both registers are full.
module histogram_frame_crc_checker #(
  parameter int unsigned FRAME_BYTES = 86
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hfcc_in_if.sink    in_i,
  hfcc_out_if.source out_o
);
  import hfcc_pkg::*;

  logic     s1_valid_q;
  in_req_t  s1_req_q;
  logic     out_valid_q, out_valid_d;
  out_req_t out_req_q;

  logic     advance;
  logic     emit;
  out_req_t res;

  // move the held request on when the result slot is free or being drained
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  hfcc_frame_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (s1_req_q),
    .emit_o    (emit),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_req_q.data_byte   <= in_i.data_byte;
      s1_req_q.frame_start <= in_i.frame_start;
    end
    if (advance && emit) begin
      out_req_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.word_index = out_req_q.word_index;
  assign out_o.word_value = out_req_q.word_value;
  assign out_o.frame_last = out_req_q.frame_last;
  assign out_o.crc_ok     = out_req_q.crc_ok;

endmodule

/* hdl/hfcc_frame_core.sv */
`timescale 1ns / 1ps
// Frame tracking core: byte position, held low byte and running CRC.
// Depends on hfcc_pkg for the request types and the CRC function.
module hfcc_frame_core #(
  parameter int unsigned FRAME_BYTES = 86
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  hfcc_pkg::in_req_t req_i,
  output logic              emit_o,
  output hfcc_pkg::out_req_t res_o
);
  import hfcc_pkg::*;

  localparam logic [PosW-1:0] LastPos  = PosW'(FRAME_BYTES - 1);
  localparam logic [PosW:0]   FrameLen = (PosW + 1)'(FRAME_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      held_q, held_d;

  logic [PosW-1:0] pos_cur;
  logic [15:0]     crc_cur;
  logic [PosW:0]   pos_next;
  logic [15:0]     word;
  logic            last;

  always_comb begin
    // restart on the start flag, whatever the state was
    pos_cur  = req_i.frame_start ? '0 : pos_q;
    crc_cur  = req_i.frame_start ? CrcInit : crc_q;
    word     = {req_i.data_byte, held_q};
    last     = (pos_cur == LastPos);
    pos_next = {1'b0, pos_cur} + 1'b1;

    emit_o           = pos_cur[0];
    res_o.word_index = pos_cur[PosW-1:1];
    res_o.word_value = word;
    res_o.frame_last = last;
    res_o.crc_ok     = last && (word == crc_cur);

    held_d = pos_cur[0] ? held_q : req_i.data_byte;
    // the trailing checksum bytes stay out of the CRC
    crc_d  = (({1'b0, pos_cur} + (PosW + 1)'(2)) < FrameLen) ?
             crc16_byte(crc_cur, req_i.data_byte) : crc_cur;
    pos_d  = pos_next[PosW-1:0];
    if (pos_next >= FrameLen) begin
      pos_d = '0;
      crc_d = CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= CrcInit;
      held_q <= '0;
    end else if (advance_i) begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      held_q <= held_d;
    end
  end

endmodule
